[design/lrsr_pkg.sv]
// lrsr_pkg: types, codes, constants and helper functions of the led ring status renderer
// no dependencies; imported by every module of the block

package lrsr_pkg;

   localparam int RING_LEDS = 12;
   localparam int PIX_W     = 4;
   localparam int NOW_W     = 40;
   localparam int END_W     = 41;
   localparam int FILL_W    = 10;
   localparam int HOLD_W    = 16;
   localparam int RES_W     = 14;
   localparam int COLOR_W   = 8;
   localparam int BRED_W    = 6;
   localparam int BGREEN_W  = 5;

   localparam logic [PIX_W-1:0] LAST_PIXEL = PIX_W'(RING_LEDS - 1);

   // volume level
   localparam logic [FILL_W-1:0] FILL_MAX   = 10'd1000;
   localparam logic [FILL_W-1:0] FILL_RESET = 10'd500;
   localparam logic [RES_W-1:0]  LIT_ROUND  = 14'd500;
   localparam int                LIT_STEP   = 1000;

   // muted frame
   localparam logic [COLOR_W-1:0] MUTE_RED   = 8'd60;
   localparam logic [PIX_W-1:0]   MUTE_PIX_A = 4'd3;
   localparam logic [PIX_W-1:0]   MUTE_PIX_B = 4'd9;

   // volume frame gradient
   localparam logic [PIX_W-1:0]   VOL_GREEN_END = 4'd8;
   localparam logic [PIX_W-1:0]   VOL_MID_END   = 4'd10;
   localparam logic [COLOR_W-1:0] VOL_GREEN     = 8'd80;
   localparam logic [COLOR_W-1:0] VOL_MID_RED   = 8'd90;
   localparam logic [COLOR_W-1:0] VOL_MID_GREEN = 8'd60;
   localparam logic [COLOR_W-1:0] VOL_TOP_RED   = 8'd120;

   // idle breath: 4000 ms triangle, red = x/50, green = x/125 by reciprocal multiply
   localparam logic [11:0] BREATH_PERIOD = 12'd4000;
   localparam logic [11:0] BREATH_HALF   = 12'd2000;
   localparam logic [10:0] RED_RECIP     = 11'd1311;
   localparam int          RED_SHIFT     = 16;
   localparam logic [11:0] GREEN_RECIP   = 12'd2098;
   localparam int          GREEN_SHIFT   = 18;

   typedef enum logic [1:0] {
      CMD_FRAME  = 2'd0,
      CMD_VOLUME = 2'd1,
      CMD_MUTE   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_BREATH = 2'd0,
      MODE_VOLUME = 2'd1,
      MODE_MUTE   = 2'd2
   } mode_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [NOW_W-1:0]    now_ms;
      logic [FILL_W-1:0]   volume_fill;
      logic [HOLD_W-1:0]   hold_ms;
      logic                mute_on;
   } item_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [NOW_W-1:0]    now_ms;
      logic [FILL_W-1:0]   volume_fill;
      logic [HOLD_W-1:0]   hold_ms;
      logic                mute_on;
      logic [RES_W-1:0]    res_sum;
   } stage_type;

   typedef struct packed {
      mode_type            mode;
      logic [PIX_W-1:0]    lit;
      logic [BRED_W-1:0]   breath_red;
      logic [BGREEN_W-1:0] breath_green;
   } frame_type;

   // (now_ms >> 5) folded mod 125: 7-bit chunks weighted by 128^k mod 125
   function automatic logic [RES_W-1:0] res_sum(input logic [34:0] v);
      logic [RES_W-1:0] c0, c1, c2, c3, c4;
      c0 = RES_W'(v[6:0]);
      c1 = RES_W'(v[13:7]);
      c2 = RES_W'(v[20:14]);
      c3 = RES_W'(v[27:21]);
      c4 = RES_W'(v[34:28]);
      return c0 + 14'd3 * c1 + 14'd9 * c2 + 14'd27 * c3 + 14'd81 * c4;
   endfunction

   // finish the mod 125 reduction of a folded sum
   function automatic logic [6:0] res_mod(input logic [RES_W-1:0] s);
      logic [8:0] t;
      t = 9'(s[13:7]) * 9'd3 + 9'(s[6:0]);
      if (t >= 9'd375)      return 7'(t - 9'd375);
      else if (t >= 9'd250) return 7'(t - 9'd250);
      else if (t >= 9'd125) return 7'(t - 9'd125);
      else                  return 7'(t);
   endfunction

   // rounded count of lit pixels for a fill level
   function automatic logic [PIX_W-1:0] lit_count(input logic [FILL_W-1:0] fill);
      logic [RES_W-1:0] v;
      logic [PIX_W-1:0] n;
      v = RES_W'(fill) * 14'd12 + LIT_ROUND;
      n = '0;
      for (int k = 1; k <= RING_LEDS; k++) begin
         if (v >= RES_W'(k * LIT_STEP)) n = n + 4'd1;
      end
      return n;
   endfunction

endpackage

[design/lrsr_front.sv]
// lrsr_front: input register and phase folding stage of the led ring status renderer
// depends on lrsr_pkg

module lrsr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  lrsr_pkg::item_type   req_item,
   input  logic                 advance,
   output logic                 st_valid,
   output lrsr_pkg::stage_type  st
);
   import lrsr_pkg::*;

   item_type  in_ff;
   logic      in_valid_ff;
   stage_type st_ff, st_in;
   logic      st_valid_ff;

   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      st_in.cmd         = in_ff.cmd;
      st_in.now_ms      = in_ff.now_ms;
      st_in.volume_fill = in_ff.volume_fill;
      st_in.hold_ms     = in_ff.hold_ms;
      st_in.mute_on     = in_ff.mute_on;
      st_in.res_sum     = res_sum(in_ff.now_ms[39:5]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            st_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_ff <= req_item;
      end
      if (advance) begin
         st_ff <= st_in;
      end
   end

   assign st_valid = st_valid_ff;
   assign st       = st_ff;

endmodule

[design/lrsr_frame.sv]
// lrsr_frame: mute, fill and overlay state, mode choice and breath color of a frame
// depends on lrsr_pkg

module lrsr_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 st_valid,
   input  lrsr_pkg::stage_type  st,
   input  logic                 commit,
   output lrsr_pkg::frame_type  frame
);
   import lrsr_pkg::*;

   logic              mute_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [END_W-1:0]  end_ff;

   logic [6:0]  phase_hi;
   logic [11:0] phase;
   logic [10:0] tri_x;
   logic [21:0] red_prod;
   logic [22:0] green_prod;

   always_comb begin
      phase_hi   = res_mod(st.res_sum);
      phase      = {phase_hi, st.now_ms[4:0]};
      tri_x      = (phase < BREATH_HALF) ? phase[10:0] : 11'(BREATH_PERIOD - phase);
      red_prod   = 22'(tri_x) * 22'(RED_RECIP);
      green_prod = 23'(tri_x) * 23'(GREEN_RECIP);

      frame.breath_red   = red_prod[RED_SHIFT +: BRED_W];
      frame.breath_green = green_prod[GREEN_SHIFT +: BGREEN_W];
      frame.lit          = lit_count(fill_ff);
      priority if (mute_ff) begin
         frame.mode = MODE_MUTE;
      end else if ({1'b0, st.now_ms} < end_ff) begin
         frame.mode = MODE_VOLUME;
      end else begin
         frame.mode = MODE_BREATH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mute_ff <= 1'b0;
         fill_ff <= FILL_RESET;
         end_ff  <= '0;
      end else if (st_valid && commit) begin
         unique case (st.cmd)
            CMD_VOLUME: begin
               fill_ff <= (st.volume_fill > FILL_MAX) ? FILL_MAX : st.volume_fill;
               end_ff  <= END_W'(st.now_ms) + END_W'(st.hold_ms);
            end
            CMD_MUTE: begin
               mute_ff <= st.mute_on;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

[design/lrsr_emit.sv]
// lrsr_emit: frame register, pixel counter and per-pixel color of the result stream
// depends on lrsr_pkg

module lrsr_emit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  lrsr_pkg::frame_type            frame,
   output logic                           free,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [lrsr_pkg::PIX_W-1:0]     pixel_index,
   output logic [lrsr_pkg::COLOR_W-1:0]   red,
   output logic [lrsr_pkg::COLOR_W-1:0]   green,
   output logic [lrsr_pkg::COLOR_W-1:0]   blue,
   output lrsr_pkg::mode_type             frame_mode,
   output logic                           last_pixel
);
   import lrsr_pkg::*;

   frame_type        frame_ff;
   logic             busy_ff;
   logic [PIX_W-1:0] idx_ff;
   logic             done;

   assign last_pixel = (idx_ff == LAST_PIXEL);
   assign done       = busy_ff && rsp_tready && last_pixel;
   assign free       = !busy_ff || done;
   assign rsp_tvalid = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_tready) begin
         busy_ff <= !last_pixel;
         idx_ff  <= last_pixel ? '0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame;
      end
   end

   always_comb begin
      pixel_index = idx_ff;
      frame_mode  = frame_ff.mode;
      red         = '0;
      green       = '0;
      blue        = '0;
      unique case (frame_ff.mode)
         MODE_MUTE: begin
            if (idx_ff == MUTE_PIX_A || idx_ff == MUTE_PIX_B) red = MUTE_RED;
         end
         MODE_VOLUME: begin
            if (idx_ff < frame_ff.lit) begin
               priority if (idx_ff < VOL_GREEN_END) begin
                  green = VOL_GREEN;
               end else if (idx_ff < VOL_MID_END) begin
                  red   = VOL_MID_RED;
                  green = VOL_MID_GREEN;
               end else begin
                  red   = VOL_TOP_RED;
               end
            end
         end
         MODE_BREATH: begin
            red   = COLOR_W'(frame_ff.breath_red);
            green = COLOR_W'(frame_ff.breath_green);
         end
         default: begin
         end
      endcase
   end

endmodule

[design/led_ring_status_renderer.sv]
// led_ring_status_renderer: top level of the twelve-pixel status ring renderer
// depends on lrsr_pkg, lrsr_front, lrsr_frame and lrsr_emit
//
// Usage:
//   The req_ channel takes one command per transfer: tuser carries the command
//   (frame, volume, mute), tdata the timestamp, volume fill, hold time and mute flag.
//   Volume and mute commands only update internal state and produce no output.
//   A frame command produces twelve rsp_ transfers, pixel 0 first, with tlast on
//   pixel 11 and the frame mode in tuser.
//   A frame's request transfer loads the input register, then the phase folding
//   stage, then the frame register, whose load raises rsp_tvalid for its first pixel.
//   Throughput: state commands are taken one per cycle while no frame waits for the
//   emitter; a frame occupies the pixel output until its twelve pixels are taken, as
//   the emitter has a single pixel counter. The next frame is loaded in the cycle
//   its predecessor's last pixel is taken, so frames stream without gaps.
//   When the receiver stalls, the current pixel holds and the two input stages fill
//   up behind a waiting frame; req_tready drops once both are occupied.
//   Reset clears the pipeline, mute flag and overlay, and sets the fill level to 500.

module led_ring_status_renderer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // now_ms[39:0], volume_fill[49:40], hold_ms[65:50],
                                    // mute_on[66], zero[71:67]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // pixel_index[3:0], red[11:4], green[19:12],
                                    // blue[27:20], zero[31:28]
   output logic [1:0]  rsp_tuser,   // frame_mode[1:0]
   output logic        rsp_tlast    // last_pixel
);
   import lrsr_pkg::*;

   item_type          req_item;
   stage_type         st;
   logic              st_valid;
   frame_type         frame;
   logic              emit_free;
   logic              advance;
   logic              load;
   logic [PIX_W-1:0]  pixel_index;
   logic [COLOR_W-1:0] red, green, blue;
   mode_type          frame_mode;
   logic              last_pixel;

   always_comb begin
      req_item.cmd         = cmd_type'(req_tuser);
      req_item.now_ms      = req_tdata[39:0];
      req_item.volume_fill = req_tdata[49:40];
      req_item.hold_ms     = req_tdata[65:50];
      req_item.mute_on     = req_tdata[66];
   end

   // a frame waits until the emitter is free; state commands in this stage never wait
   assign load    = st_valid && (st.cmd == CMD_FRAME) && emit_free;
   assign advance = !st_valid || (st.cmd != CMD_FRAME) || emit_free;

   lrsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .st_valid   (st_valid),
      .st         (st)
   );

   lrsr_frame u_frame (
      .clock    (clock),
      .reset    (reset),
      .st_valid (st_valid),
      .st       (st),
      .commit   (advance),
      .frame    (frame)
   );

   lrsr_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .frame       (frame),
      .free        (emit_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .pixel_index (pixel_index),
      .red         (red),
      .green       (green),
      .blue        (blue),
      .frame_mode  (frame_mode),
      .last_pixel  (last_pixel)
   );

   assign rsp_tdata = {4'd0, blue, green, red, pixel_index};
   assign rsp_tuser = frame_mode;
   assign rsp_tlast = last_pixel;

endmodule

[test/tb_led_ring_status_renderer.sv]
// tb_led_ring_status_renderer: self-checking bench for the led ring status renderer
// drives commands with bursty timing, predicts every pixel and checks the pixel stream
// depends on lrsr_pkg and led_ring_status_renderer

module tb_led_ring_status_renderer;
   import lrsr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 400;

   typedef struct {
      logic [PIX_W-1:0]   idx;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      mode_type           mode;
      logic               is_last;
   } pixel_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // now_ms, volume_fill, hold_ms, mute_on, zero pad
   logic [1:0]  req_tuser = '0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // pixel_index, red, green, blue, zero pad
   logic [1:0]  rsp_tuser;        // frame_mode
   logic        rsp_tlast;

   item_type command_queue[$];
   pixel_rec_type pending_pixels[$];

   // predicted block state
   logic              muted_now = 1'b0;
   logic [FILL_W-1:0] fill_now = FILL_RESET;
   logic [END_W-1:0]  overlay_until = '0;

   bit req_taken = 1'b0;
   int burst_left = 1;
   int gap_left = 0;
   int quiet_cycles = 0;
   int pixels_seen = 0;
   int errors = 0;

   led_ring_status_renderer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial forever #5 clock = ~clock;

   task automatic push_item(input cmd_type c, input logic [NOW_W-1:0] now,
                            input logic [FILL_W-1:0] fill, input logic [HOLD_W-1:0] hold,
                            input logic mute);
      item_type it;
      it.cmd = c;
      it.now_ms = now;
      it.volume_fill = fill;
      it.hold_ms = hold;
      it.mute_on = mute;
      command_queue.push_back(it);
   endtask

   // update the state for one command and queue the pixels of a frame
   task automatic render_command(input item_type it);
      pixel_rec_type px;
      int lit;
      longint phase;
      longint ramp;
      case (it.cmd)
         CMD_VOLUME: begin
            fill_now = (it.volume_fill > FILL_MAX) ? FILL_MAX : it.volume_fill;
            overlay_until = END_W'(it.now_ms) + END_W'(it.hold_ms);
         end
         CMD_MUTE: muted_now = it.mute_on;
         CMD_FRAME: begin
            lit = (int'(fill_now) * 12 + 500) / 1000;
            if (lit > RING_LEDS) lit = RING_LEDS;
            phase = longint'(it.now_ms) % 4000;
            ramp = (phase < 2000) ? phase : 4000 - phase;
            for (int i = 0; i < RING_LEDS; i++) begin
               px.idx = PIX_W'(i);
               px.blue = '0;
               px.red = '0;
               px.green = '0;
               px.is_last = (i == RING_LEDS - 1);
               if (muted_now) begin
                  px.mode = MODE_MUTE;
                  if (i == 3 || i == 9) px.red = 8'd60;
               end else if (END_W'(it.now_ms) < overlay_until) begin
                  px.mode = MODE_VOLUME;
                  if (i < lit) begin
                     if (i < 8) begin
                        px.green = 8'd80;
                     end else if (i < 10) begin
                        px.red = 8'd90;
                        px.green = 8'd60;
                     end else begin
                        px.red = 8'd120;
                     end
                  end
               end else begin
                  px.mode = MODE_BREATH;
                  px.red = COLOR_W'(ramp / 50);
                  px.green = COLOR_W'(ramp / 125);
               end
               pending_pixels.push_back(px);
            end
         end
         default: ;
      endcase
   endtask

   // sender: bursts of transfers separated by random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // item still on offer, hold it
      end else if (gap_left > 0) begin
         gap_left--;
         req_tvalid <= 1'b0;
      end else if (command_queue.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= {5'b0, command_queue[0].mute_on, command_queue[0].hold_ms,
                       command_queue[0].volume_fill, command_queue[0].now_ms};
         req_tuser <= command_queue[0].cmd;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver: changing stall styles plus one long hold-off
   int style = 0;
   int style_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int stall_phase = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_phase++;
         if (!hold_done && pixels_seen >= 240) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (style_left == 0) begin
            style = $urandom_range(0, 3);
            style_left = $urandom_range(20, 120);
         end else begin
            style_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (stall_phase % 5) != 0;
               default: rsp_tready <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   // monitor: predict on each command transfer, check each pixel transfer
   always @(posedge clock) begin
      pixel_rec_type want;
      req_taken = req_tvalid && req_tready;
      if (reset) begin
         muted_now = 1'b0;
         fill_now = FILL_RESET;
         overlay_until = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            render_command(command_queue.pop_front());
         end
         if (rsp_tvalid && rsp_tready) begin
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
               errors++;
               $display({"%0t: unexpected pixel, expected none, ",
                         "got idx %0d rgb %0d,%0d,%0d mode %0d last %0d"},
                        $time, rsp_tdata[3:0], rsp_tdata[11:4], rsp_tdata[19:12],
                        rsp_tdata[27:20], rsp_tuser, rsp_tlast);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_tdata[3:0] !== want.idx || rsp_tdata[11:4] !== want.red ||
                   rsp_tdata[19:12] !== want.green || rsp_tdata[27:20] !== want.blue ||
                   rsp_tuser !== want.mode || rsp_tlast !== want.is_last) begin
                  errors++;
                  $display({"%0t: pixel mismatch, ",
                            "expected idx %0d rgb %0d,%0d,%0d mode %0d last %0d, ",
                            "got idx %0d rgb %0d,%0d,%0d mode %0d last %0d"},
                           $time, want.idx, want.red, want.green, want.blue, want.mode,
                           want.is_last, rsp_tdata[3:0], rsp_tdata[11:4],
                           rsp_tdata[19:12], rsp_tdata[27:20], rsp_tuser, rsp_tlast);
               end
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("tb_led_ring_status_renderer NOT OK");
      $finish;
   end

   initial begin
      logic [NOW_W-1:0]  clk_ms;
      logic [FILL_W-1:0] fill;
      logic [HOLD_W-1:0] hold;
      cmd_type           c;
      int                roll;
      int                produced;

      // breath extremes from reset state
      push_item(CMD_FRAME, 40'd0, 10'd0, 16'd0, 1'b0);
      push_item(CMD_FRAME, 40'd1999, 10'd0, 16'd0, 1'b0);
      push_item(CMD_FRAME, 40'd2000, 10'd0, 16'd0, 1'b0);
      push_item(CMD_FRAME, 40'd3999, 10'd0, 16'd0, 1'b0);
      // lit count rounding edges and fill saturation
      push_item(CMD_VOLUME, 40'd4000, 10'd0, 16'hFFFF, 1'b0);
      push_item(CMD_FRAME, 40'd4000, 10'd0, 16'd0, 1'b0);
      push_item(CMD_VOLUME, 40'd4001, 10'd42, 16'd100, 1'b0);
      push_item(CMD_FRAME, 40'd4100, 10'd0, 16'd0, 1'b0);
      push_item(CMD_VOLUME, 40'd5000, 10'd958, 16'd10, 1'b0);
      push_item(CMD_FRAME, 40'd5009, 10'd0, 16'd0, 1'b0);
      push_item(CMD_VOLUME, 40'd6000, 10'd1023, 16'd1, 1'b0);
      push_item(CMD_FRAME, 40'd6000, 10'd0, 16'd0, 1'b0);
      // zero hold: overlay already over at the same millisecond
      push_item(CMD_VOLUME, 40'd7000, 10'd1000, 16'd0, 1'b0);
      push_item(CMD_FRAME, 40'd7000, 10'd0, 16'd0, 1'b0);
      // mute wins over an active overlay, unused command ignored
      push_item(CMD_MUTE, 40'd7001, 10'd0, 16'd0, 1'b1);
      push_item(CMD_VOLUME, 40'd7002, 10'd700, 16'hFFFF, 1'b0);
      push_item(CMD_FRAME, 40'd7003, 10'd0, 16'd0, 1'b0);
      push_item(CMD_NONE, 40'hFF_FFFF_FFFF, 10'h3FF, 16'hFFFF, 1'b1);
      push_item(CMD_FRAME, 40'd7004, 10'd0, 16'd0, 1'b0);
      push_item(CMD_MUTE, 40'd7005, 10'd0, 16'd0, 1'b0);
      push_item(CMD_FRAME, 40'd7006, 10'd0, 16'd0, 1'b0);
      // overlay end beyond the timestamp range
      push_item(CMD_VOLUME, 40'hFF_FFFF_FFFF, 10'd1000, 16'hFFFF, 1'b0);
      push_item(CMD_FRAME, 40'hFF_FFFF_FFFF, 10'd0, 16'd0, 1'b0);
      push_item(CMD_VOLUME, 40'hFF_FFFF_FFFF, 10'd0, 16'd0, 1'b0);
      push_item(CMD_FRAME, 40'hFF_FFFF_FFFF, 10'd0, 16'd0, 1'b0);

      produced = command_queue.size();
      clk_ms = NOW_W'($urandom_range(0, 100000));
      while (produced < 460) begin
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            clk_ms[31:0] = $urandom;
            clk_ms[39:32] = 8'($urandom_range(0, 255));
         end else if (roll < 20) begin
            clk_ms += NOW_W'($urandom_range(0, 20));
         end else if (roll < 85) begin
            clk_ms += NOW_W'($urandom_range(0, 1500));
         end else begin
            clk_ms += NOW_W'($urandom_range(0, 70000));
         end
         fill = FILL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(900, 1023)
                                                    : $urandom_range(0, 1023));
         hold = HOLD_W'($urandom_range(0, 1) ? $urandom_range(0, 4000)
                                             : $urandom_range(0, 65535));
         roll = $urandom_range(0, 99);
         if (roll < 52) c = CMD_FRAME;
         else if (roll < 80) c = CMD_VOLUME;
         else if (roll < 92) c = CMD_MUTE;
         else c = CMD_NONE;
         push_item(c, clk_ms, fill, hold, $urandom_range(0, 2) == 0);
         produced++;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (command_queue.size() > 0 || pending_pixels.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("tb_led_ring_status_renderer OK");
      else
         $display("tb_led_ring_status_renderer NOT OK");
      $finish;
   end

endmodule
